// ===== rtl/gzvd_pkg.sv =====
// gzvd_pkg: shared types, widths and register codes for the zero-velocity detector
// used by every module of the block; depends on nothing

package gzvd_pkg;

   // window length in samples, legal range 2 to 16
   localparam int WIN_LEN = 3;

   localparam int SAMPLE_W = 24;
   localparam int GRAV_W   = 21;
   localparam int WEIGHT_W = 32;
   localparam int STAT_W   = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam int IDX_W  = $clog2(WIN_LEN);
   localparam int FILL_W = $clog2(WIN_LEN + 1);

   // mean vector, its squared norm and the projection
   localparam int SUM_W  = SAMPLE_W + $clog2(WIN_LEN);
   localparam int SQ_W   = 2 * SUM_W;
   localparam int PROD_W = GRAV_W + SUM_W;
   localparam int PROJ_W = GRAV_W + 1;

   // deviation terms and the two energy sums
   localparam int OP_W  = SAMPLE_W + 1;
   localparam int SQM_W = 2 * SAMPLE_W;
   localparam int A_W   = 2 * SAMPLE_W + $clog2(3 * WIN_LEN);
   localparam int R_W   = 2 * SAMPLE_W - 2 + $clog2(3 * WIN_LEN);
   localparam int PA_W  = (A_W + 1) / 2;
   localparam int PR_W  = (R_W + 1) / 2;
   localparam int MB_W  = PA_W;

   // weighted total and the divide by the window length
   localparam int X_W       = WEIGHT_W + A_W + 9;
   localparam int T_W       = X_W - 40;
   localparam int DIV_STEPS = 4;
   localparam int TP_W      = ((T_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
   localparam int DIV_CYC   = TP_W / DIV_STEPS;
   localparam int REM_W     = $clog2(WIN_LEN) + 1;

   localparam int STEP_MAX0 = (SUM_W > GRAV_W) ? SUM_W : GRAV_W;
   localparam int STEP_MAX  = (STEP_MAX0 > DIV_CYC) ? STEP_MAX0 : DIV_CYC;
   localparam int STEP_W    = $clog2(STEP_MAX + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register reset values
   localparam logic [GRAV_W-1:0]   GRAVITY_RESET   = 21'd643430;
   localparam logic [WEIGHT_W-1:0] ACCEL_W_RESET   = 32'd6553600;
   localparam logic [WEIGHT_W-1:0] GYRO_W_RESET    = 32'd37549375;
   localparam logic [STAT_W-1:0]   THRESHOLD_RESET = 48'd1966080000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRAVITY      = 3'd0,
      CSR_ACCEL_WEIGHT = 3'd1,
      CSR_GYRO_WEIGHT  = 3'd2,
      CSR_THRESHOLD    = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] accel_x;
      logic signed [SAMPLE_W-1:0] accel_y;
      logic signed [SAMPLE_W-1:0] accel_z;
      logic signed [SAMPLE_W-1:0] rate_x;
      logic signed [SAMPLE_W-1:0] rate_y;
      logic signed [SAMPLE_W-1:0] rate_z;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] test_statistic;
      logic              stationary;
   } rsp_type;

   typedef struct packed {
      req_type sample;
      logic    emit;
   } qentry_type;

   typedef struct packed {
      logic [GRAV_W-1:0]   gravity_magnitude;
      logic [WEIGHT_W-1:0] accel_weight;
      logic [WEIGHT_W-1:0] gyro_weight;
      logic [STAT_W-1:0]   stationary_threshold;
   } cfg_type;

   // pick one accel axis of a sample
   function automatic logic signed [SAMPLE_W-1:0] accel_axis(req_type s, logic [1:0] a);
      logic signed [SAMPLE_W-1:0] v;
      unique case (a)
         2'd0:    v = s.accel_x;
         2'd1:    v = s.accel_y;
         default: v = s.accel_z;
      endcase
      return v;
   endfunction

   // pick one rate axis of a sample
   function automatic logic signed [SAMPLE_W-1:0] rate_axis(req_type s, logic [1:0] a);
      logic signed [SAMPLE_W-1:0] v;
      unique case (a)
         2'd0:    v = s.rate_x;
         2'd1:    v = s.rate_y;
         default: v = s.rate_z;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/gzvd_queue.sv =====
// gzvd_queue: short flop queue between the sample front end and the compute engine
// depends on gzvd_pkg for the entry type and depth

module gzvd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  gzvd_pkg::qentry_type  push_entry,
   output logic                  full,
   input  logic                  pop,
   output gzvd_pkg::qentry_type  pop_entry,
   output logic                  empty
);

   gzvd_pkg::qentry_type                 mem_ff [gzvd_pkg::QUEUE_DEPTH];
   logic [gzvd_pkg::QPTR_W-1:0]          wptr_ff, wptr_in;
   logic [gzvd_pkg::QPTR_W-1:0]          rptr_ff, rptr_in;
   logic [gzvd_pkg::QCNT_W-1:0]          cnt_ff, cnt_in;
   logic                                 do_push, do_pop;

   assign full      = (cnt_ff == gzvd_pkg::QCNT_W'(gzvd_pkg::QUEUE_DEPTH));
   assign empty     = (cnt_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == gzvd_pkg::QPTR_W'(gzvd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == gzvd_pkg::QPTR_W'(gzvd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_entry;
      end
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= gzvd_pkg::QCNT_W'(gzvd_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_cnt_grow: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count did not grow on push");

endmodule

// ===== rtl/gzvd_front.sv =====
// gzvd_front: takes samples, tracks window fill and tags the ones that complete a window
// depends on gzvd_pkg; feeds gzvd_queue

module gzvd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gzvd_pkg::req_type     req_data,
   input  logic                  q_full,
   output logic                  q_push,
   output gzvd_pkg::qentry_type  q_entry
);

   logic [gzvd_pkg::FILL_W-1:0] fill_ff, fill_in;

   assign req_stall      = q_full;
   assign q_push         = req_valid && !q_full;
   assign q_entry.sample = req_data;
   // window complete once this sample lands
   assign q_entry.emit   = (fill_ff >= gzvd_pkg::FILL_W'(gzvd_pkg::WIN_LEN - 1));

   always_comb begin
      fill_in = fill_ff;
      if (q_push && (fill_ff != gzvd_pkg::FILL_W'(gzvd_pkg::WIN_LEN))) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= gzvd_pkg::FILL_W'(gzvd_pkg::WIN_LEN))
      else $error("fill count beyond window");

endmodule

// ===== rtl/gzvd_back.sv =====
// gzvd_back: window store and sequential statistic engine (sum, root, divide, weigh)
// depends on gzvd_pkg; drains gzvd_queue and drives the result register

module gzvd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  gzvd_pkg::cfg_type     cfg,
   input  gzvd_pkg::qentry_type  q_entry,
   input  logic                  q_empty,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gzvd_pkg::rsp_type     rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SUM, ST_SQ, ST_ROOT, ST_PMUL, ST_PDIV,
      ST_ACC, ST_DRAIN, ST_WMUL, ST_DIV, ST_DONE
   } state_type;

   state_type                               state_ff, state_in;
   gzvd_pkg::req_type                       win_ff [gzvd_pkg::WIN_LEN];
   gzvd_pkg::req_type                       win_in [gzvd_pkg::WIN_LEN];
   logic [gzvd_pkg::IDX_W-1:0]              k_ff, k_in;
   logic [1:0]                              axis_ff, axis_in;
   logic                                    phase_ff, phase_in;
   logic [gzvd_pkg::STEP_W-1:0]             step_ff, step_in;
   logic signed [gzvd_pkg::SUM_W-1:0]       sum_ff [3];
   logic signed [gzvd_pkg::SUM_W-1:0]       sum_in [3];
   logic [gzvd_pkg::SQ_W-1:0]               sq_ff, sq_in, rx_ff, rx_in;
   logic [gzvd_pkg::SQ_W-1:0]               res_ff, res_in, bit_ff, bit_in;
   logic [gzvd_pkg::SUM_W-1:0]              n_ff, n_in, rem_ff, rem_in;
   logic [gzvd_pkg::GRAV_W-1:0]             qd_ff, qd_in;
   logic signed [gzvd_pkg::PROJ_W-1:0]      proj_ff [3];
   logic signed [gzvd_pkg::PROJ_W-1:0]      proj_in [3];
   logic signed [gzvd_pkg::OP_W-1:0]        op_ff, op_in;
   logic                                    op_vld_ff, op_vld_in, op_rate_ff, op_rate_in;
   logic                                    acc_clr;
   logic [gzvd_pkg::A_W-1:0]                a_ff, a_in;
   logic [gzvd_pkg::R_W-1:0]                r_ff, r_in;
   logic [gzvd_pkg::X_W-1:0]                x_ff, x_in;
   logic [gzvd_pkg::TP_W-1:0]               dv_ff, dv_in;
   logic [gzvd_pkg::REM_W-1:0]              dr_ff, dr_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   gzvd_pkg::rsp_type                       rsp_ff, rsp_in;

   logic signed [gzvd_pkg::SUM_W-1:0]       sel_sum;
   logic signed [gzvd_pkg::PROJ_W-1:0]      sel_proj;
   gzvd_pkg::req_type                       cur;
   logic signed [gzvd_pkg::SQ_W-1:0]        sum_sq;
   logic signed [2*gzvd_pkg::OP_W-1:0]      op_sq;
   logic [gzvd_pkg::SQM_W-1:0]              op_sqm;
   logic [gzvd_pkg::STAT_W-1:0]             stat_sat;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign cur       = win_ff[k_ff];
   assign sum_sq    = sel_sum * sel_sum;
   assign op_sq     = op_ff * op_ff;
   assign op_sqm    = op_sq[gzvd_pkg::SQM_W-1:0];
   assign stat_sat  = (|dv_ff[gzvd_pkg::TP_W-1:gzvd_pkg::STAT_W]) ? '1
                                                                  : dv_ff[gzvd_pkg::STAT_W-1:0];

   always_comb begin
      unique case (axis_ff)
         2'd0: begin
            sel_sum  = sum_ff[0];
            sel_proj = proj_ff[0];
         end
         2'd1: begin
            sel_sum  = sum_ff[1];
            sel_proj = proj_ff[1];
         end
         default: begin
            sel_sum  = sum_ff[2];
            sel_proj = proj_ff[2];
         end
      endcase
   end

   // energy accumulators, one squared term a cycle
   always_comb begin
      a_in = a_ff;
      r_in = r_ff;
      if (acc_clr) begin
         a_in = '0;
         r_in = '0;
      end else if (op_vld_ff) begin
         if (op_rate_ff) begin
            r_in = r_ff + {{(gzvd_pkg::R_W-gzvd_pkg::SQM_W){1'b0}}, op_sqm};
         end else begin
            a_in = a_ff + {{(gzvd_pkg::A_W-gzvd_pkg::SQM_W){1'b0}}, op_sqm};
         end
      end
   end

   always_comb begin
      logic [gzvd_pkg::SQ_W:0]               trial;
      logic [gzvd_pkg::SUM_W:0]              rem2, rsub;
      logic                                  ge;
      logic [gzvd_pkg::SUM_W-1:0]            mag;
      logic [gzvd_pkg::PROD_W-1:0]           prod;
      logic [gzvd_pkg::GRAV_W-1:0]           q;
      logic [gzvd_pkg::WEIGHT_W-1:0]         mul_a;
      logic [gzvd_pkg::MB_W-1:0]             mul_b;
      logic [gzvd_pkg::WEIGHT_W+gzvd_pkg::MB_W-1:0] mul_p;
      logic [gzvd_pkg::X_W-1:0]              addend, xsum;
      logic [gzvd_pkg::REM_W-1:0]            dr, dr2;
      logic [gzvd_pkg::TP_W-1:0]             dv;
      logic                                  ge2;

      state_in     = state_ff;
      win_in       = win_ff;
      k_in         = k_ff;
      axis_in      = axis_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      rx_in        = rx_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      n_in         = n_ff;
      rem_in       = rem_ff;
      qd_in        = qd_ff;
      proj_in      = proj_ff;
      op_in        = op_ff;
      op_vld_in    = 1'b0;
      op_rate_in   = op_rate_ff;
      acc_clr      = 1'b0;
      x_in         = x_ff;
      dv_in        = dv_ff;
      dr_in        = dr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      trial  = {1'b0, res_ff} + {1'b0, bit_ff};
      rem2   = {rem_ff, qd_ff[gzvd_pkg::GRAV_W-1]};
      rsub   = rem2 - {1'b0, n_ff};
      ge     = (rem2 >= {1'b0, n_ff});
      mag    = sel_sum[gzvd_pkg::SUM_W-1] ? gzvd_pkg::SUM_W'(-sel_sum)
                                          : gzvd_pkg::SUM_W'(sel_sum);
      prod   = gzvd_pkg::PROD_W'(cfg.gravity_magnitude) * gzvd_pkg::PROD_W'(mag);
      q      = {qd_ff[gzvd_pkg::GRAV_W-2:0], ge};

      mul_a  = step_ff[1] ? cfg.gyro_weight : cfg.accel_weight;
      case (step_ff[1:0])
         2'd0:    mul_b = gzvd_pkg::MB_W'(a_ff[gzvd_pkg::PA_W-1:0]);
         2'd1:    mul_b = gzvd_pkg::MB_W'(a_ff[gzvd_pkg::A_W-1:gzvd_pkg::PA_W]);
         2'd2:    mul_b = gzvd_pkg::MB_W'(r_ff[gzvd_pkg::PR_W-1:0]);
         default: mul_b = gzvd_pkg::MB_W'(r_ff[gzvd_pkg::R_W-1:gzvd_pkg::PR_W]);
      endcase
      mul_p  = gzvd_pkg::WEIGHT_W'(mul_a) * mul_b;
      case (step_ff[1:0])
         2'd0:    addend = gzvd_pkg::X_W'(mul_p) << 8;
         2'd1:    addend = gzvd_pkg::X_W'(mul_p) << (8 + gzvd_pkg::PA_W);
         2'd2:    addend = gzvd_pkg::X_W'(mul_p);
         default: addend = gzvd_pkg::X_W'(mul_p) << gzvd_pkg::PR_W;
      endcase
      xsum   = x_ff + addend;

      // radix-16 restoring divide by the window length
      dr = dr_ff;
      dv = dv_ff;
      for (int j = 0; j < gzvd_pkg::DIV_STEPS; j++) begin
         dr2 = {dr[gzvd_pkg::REM_W-2:0], dv[gzvd_pkg::TP_W-1]};
         ge2 = (dr2 >= gzvd_pkg::REM_W'(gzvd_pkg::WIN_LEN));
         dr  = ge2 ? dr2 - gzvd_pkg::REM_W'(gzvd_pkg::WIN_LEN) : dr2;
         dv  = {dv[gzvd_pkg::TP_W-2:0], ge2};
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               for (int i = 0; i < gzvd_pkg::WIN_LEN - 1; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               win_in[gzvd_pkg::WIN_LEN-1] = q_entry.sample;
               if (q_entry.emit) begin
                  state_in = ST_SUM;
                  k_in     = '0;
                  sum_in   = '{default: '0};
               end
            end
         end
         ST_SUM: begin
            for (int i = 0; i < 3; i++) begin
               sum_in[i] = sum_ff[i] + gzvd_pkg::SUM_W'(gzvd_pkg::accel_axis(cur, 2'(i)));
            end
            k_in = k_ff + 1'b1;
            if (k_ff == gzvd_pkg::IDX_W'(gzvd_pkg::WIN_LEN - 1)) begin
               state_in = ST_SQ;
               axis_in  = 2'd0;
               sq_in    = '0;
            end
         end
         ST_SQ: begin
            sq_in   = sq_ff + gzvd_pkg::SQ_W'(sum_sq);
            axis_in = axis_ff + 1'b1;
            if (axis_ff == 2'd2) begin
               state_in = ST_ROOT;
               rx_in    = sq_ff + gzvd_pkg::SQ_W'(sum_sq);
               res_in   = '0;
               bit_in   = gzvd_pkg::SQ_W'(1) << (gzvd_pkg::SQ_W - 2);
               step_in  = '0;
            end
         end
         ST_ROOT: begin
            if ({1'b0, rx_ff} >= trial) begin
               rx_in  = rx_ff - trial[gzvd_pkg::SQ_W-1:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 1'b1;
            if (step_ff == gzvd_pkg::STEP_W'(gzvd_pkg::SUM_W - 1)) begin
               state_in = ST_PMUL;
               n_in     = res_in[gzvd_pkg::SUM_W-1:0];
               axis_in  = 2'd0;
            end
         end
         ST_PMUL: begin
            if (n_ff == '0) begin
               // zero mean force: no gravity direction
               proj_in[axis_ff] = '0;
               axis_in          = axis_ff + 1'b1;
               if (axis_ff == 2'd2) begin
                  state_in = ST_ACC;
                  k_in     = '0;
                  axis_in  = 2'd0;
                  phase_in = 1'b0;
                  acc_clr  = 1'b1;
               end
            end else begin
               rem_in   = prod[gzvd_pkg::PROD_W-1:gzvd_pkg::GRAV_W];
               qd_in    = prod[gzvd_pkg::GRAV_W-1:0];
               step_in  = '0;
               state_in = ST_PDIV;
            end
         end
         ST_PDIV: begin
            rem_in  = ge ? rsub[gzvd_pkg::SUM_W-1:0] : rem2[gzvd_pkg::SUM_W-1:0];
            qd_in   = q;
            step_in = step_ff + 1'b1;
            if (step_ff == gzvd_pkg::STEP_W'(gzvd_pkg::GRAV_W - 1)) begin
               proj_in[axis_ff] = sel_sum[gzvd_pkg::SUM_W-1] ? -$signed({1'b0, q})
                                                             : $signed({1'b0, q});
               axis_in = axis_ff + 1'b1;
               if (axis_ff == 2'd2) begin
                  state_in = ST_ACC;
                  k_in     = '0;
                  axis_in  = 2'd0;
                  phase_in = 1'b0;
                  acc_clr  = 1'b1;
               end else begin
                  state_in = ST_PMUL;
               end
            end
         end
         ST_ACC: begin
            op_vld_in  = 1'b1;
            op_rate_in = phase_ff;
            if (phase_ff) begin
               op_in = gzvd_pkg::OP_W'(gzvd_pkg::rate_axis(cur, axis_ff));
            end else begin
               op_in = gzvd_pkg::OP_W'(gzvd_pkg::accel_axis(cur, axis_ff))
                     - gzvd_pkg::OP_W'(sel_proj);
            end
            phase_in = !phase_ff;
            if (phase_ff) begin
               axis_in = axis_ff + 1'b1;
               if (axis_ff == 2'd2) begin
                  axis_in = 2'd0;
                  k_in    = k_ff + 1'b1;
                  if (k_ff == gzvd_pkg::IDX_W'(gzvd_pkg::WIN_LEN - 1)) begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            x_in     = '0;
            step_in  = '0;
            state_in = ST_WMUL;
         end
         ST_WMUL: begin
            x_in    = xsum;
            step_in = step_ff + 1'b1;
            if (step_ff == gzvd_pkg::STEP_W'(3)) begin
               dv_in    = gzvd_pkg::TP_W'(xsum[gzvd_pkg::X_W-1:40]);
               dr_in    = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            dv_in   = dv;
            dr_in   = dr;
            step_in = step_ff + 1'b1;
            if (step_ff == gzvd_pkg::STEP_W'(gzvd_pkg::DIV_CYC - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.test_statistic = stat_sat;
               rsp_in.stationary     = (stat_sat < cfg.stationary_threshold);
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      sum_ff  <= sum_in;
      sq_ff   <= sq_in;
      rx_ff   <= rx_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      qd_ff   <= qd_in;
      proj_ff <= proj_in;
      op_ff   <= op_in;
      op_rate_ff <= op_rate_in;
      a_ff    <= a_in;
      r_ff    <= r_in;
      x_ff    <= x_in;
      dv_ff   <= dv_in;
      dr_ff   <= dr_in;
      rsp_ff  <= rsp_in;
      k_ff    <= k_in;
      axis_ff <= axis_in;
      phase_ff <= phase_in;
      step_ff <= step_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_vld_ff    <= op_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // projection never exceeds gravity because |s_i| <= n
   a_proj_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PDIV && step_ff == gzvd_pkg::STEP_W'(gzvd_pkg::GRAV_W - 1))
      |-> (q_pop == 1'b0) && ($unsigned(qd_in) <= cfg.gravity_magnitude))
      else $error("projection above gravity");

   a_flag_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE)
      |=> rsp_valid_ff && (rsp_ff.stationary ==
                           (rsp_ff.test_statistic < cfg.stationary_threshold)))
      else $error("stationary flag disagrees with statistic");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_IDLE) || (state_ff == ST_SUM))
      else $error("engine left idle without a window");

endmodule

// ===== rtl/glrt_zero_velocity_detector_core.sv =====
// glrt_zero_velocity_detector_core: top level of the zero-velocity detector
// depends on gzvd_pkg, gzvd_front, gzvd_queue and gzvd_back
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req_data  (gzvd_pkg::req_type, one imu sample)
//  rsp     | out       | rsp_valid / rsp_stall | rsp_data  (gzvd_pkg::rsp_type, statistic + flag)
//  csr     | in        | csr_valid / csr_ready | csr_index, csr_data (register write)
//
// - a sample that does not complete a window is popped while the engine is idle and only shifts the window store
// - a window-completing sample runs the engine, which uses a bit-serial square root and a
//   projection divider that is shared by all three axes
// - with zero mean force the projection divides are skipped and every projection
//   term is set to zero
// - the two-entry queue keeps taking samples while the engine works; req_stall rises when full
// - a finished result waits in the output register; the engine holds in its last state
//   until that register is free
// - reset is synchronous; the window store is not cleared, the fill counter guards it

module glrt_zero_velocity_detector_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gzvd_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gzvd_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gzvd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gzvd_pkg::CSR_DATA_W-1:0]   csr_data
);

   gzvd_pkg::cfg_type     cfg_ff, cfg_in;
   gzvd_pkg::qentry_type  push_entry, pop_entry;
   logic                  q_push, q_full, q_pop, q_empty;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            gzvd_pkg::CSR_GRAVITY:
               cfg_in.gravity_magnitude = csr_data[gzvd_pkg::GRAV_W-1:0];
            gzvd_pkg::CSR_ACCEL_WEIGHT:
               cfg_in.accel_weight = csr_data[gzvd_pkg::WEIGHT_W-1:0];
            gzvd_pkg::CSR_GYRO_WEIGHT:
               cfg_in.gyro_weight = csr_data[gzvd_pkg::WEIGHT_W-1:0];
            gzvd_pkg::CSR_THRESHOLD:
               cfg_in.stationary_threshold = csr_data[gzvd_pkg::STAT_W-1:0];
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gravity_magnitude    <= gzvd_pkg::GRAVITY_RESET;
         cfg_ff.accel_weight         <= gzvd_pkg::ACCEL_W_RESET;
         cfg_ff.gyro_weight          <= gzvd_pkg::GYRO_W_RESET;
         cfg_ff.stationary_threshold <= gzvd_pkg::THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: accept and tag samples
   gzvd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   // decoupling queue
   gzvd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   // statistic engine and result register
   gzvd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_entry   (pop_entry),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for glrt_zero_velocity_detector_core
// depends on gzvd_pkg and the core; an in-bench window model predicts every statistic
`timescale 1ns / 1ps

module tb;

   localparam logic [gzvd_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd6;  // no register behind this index
   localparam logic [gzvd_pkg::STAT_W-1:0] STAT_MAX = {gzvd_pkg::STAT_W{1'b1}};
   localparam int REQ_W = $bits(gzvd_pkg::req_type);
   localparam int DRAIN_CYCLES = 300;    // extra wait after the last expected result
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic signed [gzvd_pkg::SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
   localparam logic signed [gzvd_pkg::SAMPLE_W-1:0] S_MIN = -24'sh800000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   gzvd_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   gzvd_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [gzvd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [gzvd_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // model copy of the registers and the sample window
   logic [gzvd_pkg::GRAV_W-1:0] mdl_gravity;
   logic [gzvd_pkg::WEIGHT_W-1:0] mdl_accel_w;
   logic [gzvd_pkg::WEIGHT_W-1:0] mdl_gyro_w;
   logic [gzvd_pkg::STAT_W-1:0] mdl_threshold;
   longint acc_win[gzvd_pkg::WIN_LEN][3];
   longint rate_win[gzvd_pkg::WIN_LEN][3];
   int win_fill = 0;

   gzvd_pkg::rsp_type stat_queue[$];
   int fail_count = 0;
   bit quiet = 1'b0;        // when set neither side idles
   int idle_cycles = 0;

   glrt_zero_velocity_detector_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // bitwise integer square root, floor
   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // shift one sample into the window; once full, queue the expected statistic
   task automatic predict_statistic(input gzvd_pkg::req_type smp);
      longint s[3];
      longint proj[3];
      longint unsigned sq, n, mag, p, acc_e, rate_e;
      longint d, r;
      logic [127:0] xa, xg, xt;
      logic [63:0] t;
      gzvd_pkg::rsp_type exp_rsp;
      for (int k = 0; k < gzvd_pkg::WIN_LEN - 1; k++) begin
         acc_win[k] = acc_win[k + 1];
         rate_win[k] = rate_win[k + 1];
      end
      acc_win[gzvd_pkg::WIN_LEN-1][0] = longint'(smp.accel_x);
      acc_win[gzvd_pkg::WIN_LEN-1][1] = longint'(smp.accel_y);
      acc_win[gzvd_pkg::WIN_LEN-1][2] = longint'(smp.accel_z);
      rate_win[gzvd_pkg::WIN_LEN-1][0] = longint'(smp.rate_x);
      rate_win[gzvd_pkg::WIN_LEN-1][1] = longint'(smp.rate_y);
      rate_win[gzvd_pkg::WIN_LEN-1][2] = longint'(smp.rate_z);
      if (win_fill < gzvd_pkg::WIN_LEN) win_fill++;
      if (win_fill < gzvd_pkg::WIN_LEN) return;
      // mean force direction, unnormalized
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         s[i] = 0;
         for (int k = 0; k < gzvd_pkg::WIN_LEN; k++) s[i] += acc_win[k][i];
         sq += longint'(s[i] * s[i]);
      end
      n = int_sqrt(sq);
      // gravity along that direction; zero when the mean force vanishes
      for (int i = 0; i < 3; i++) begin
         mag = (s[i] < 0) ? -s[i] : s[i];
         p = (n == 0) ? 0 : (longint'(mdl_gravity) * mag) / n;
         proj[i] = (s[i] < 0) ? -longint'(p) : longint'(p);
      end
      acc_e = 0;
      rate_e = 0;
      for (int k = 0; k < gzvd_pkg::WIN_LEN; k++) begin
         for (int i = 0; i < 3; i++) begin
            d = acc_win[k][i] - proj[i];
            r = rate_win[k][i];
            acc_e += d * d;
            rate_e += r * r;
         end
      end
      xa = 128'(mdl_accel_w) * 128'(acc_e);
      xg = 128'(mdl_gyro_w) * 128'(rate_e);
      xt = (xa << 8) + xg;
      t = xt[103:40];
      t = t / gzvd_pkg::WIN_LEN;
      exp_rsp.test_statistic = (t > 64'(STAT_MAX)) ? STAT_MAX : t[gzvd_pkg::STAT_W-1:0];
      exp_rsp.stationary = (exp_rsp.test_statistic < mdl_threshold);
      stat_queue.insert(stat_queue.size(), exp_rsp);
   endtask

   // one sample transaction, with an occasional idle gap first unless quiet is set
   task automatic send_sample(input gzvd_pkg::req_type smp);
      if (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= smp;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      predict_statistic(smp);
   endtask

   // register write transaction; only used while the core is idle
   task automatic write_reg(input logic [gzvd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [gzvd_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         gzvd_pkg::CSR_GRAVITY:      mdl_gravity = val[gzvd_pkg::GRAV_W-1:0];
         gzvd_pkg::CSR_ACCEL_WEIGHT: mdl_accel_w = val[gzvd_pkg::WEIGHT_W-1:0];
         gzvd_pkg::CSR_GYRO_WEIGHT:  mdl_gyro_w = val[gzvd_pkg::WEIGHT_W-1:0];
         gzvd_pkg::CSR_THRESHOLD:    mdl_threshold = val[gzvd_pkg::STAT_W-1:0];
         default: ;
      endcase
      // wait with valid low so back-to-back writes never drive valid twice in a step
      @(posedge clock);
   endtask

   task automatic write_all(input logic [gzvd_pkg::GRAV_W-1:0] g,
                            input logic [gzvd_pkg::WEIGHT_W-1:0] aw,
                            input logic [gzvd_pkg::WEIGHT_W-1:0] gw,
                            input logic [gzvd_pkg::STAT_W-1:0] th);
      write_reg(gzvd_pkg::CSR_GRAVITY, gzvd_pkg::CSR_DATA_W'(g));
      write_reg(gzvd_pkg::CSR_ACCEL_WEIGHT, gzvd_pkg::CSR_DATA_W'(aw));
      write_reg(gzvd_pkg::CSR_GYRO_WEIGHT, gzvd_pkg::CSR_DATA_W'(gw));
      write_reg(gzvd_pkg::CSR_THRESHOLD, th);
   endtask

   // wait for every statistic, then for samples still in flight
   task automatic drain();
      req_valid <= 1'b0;
      while (stat_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic gzvd_pkg::req_type make_sample(input bit calm);
      gzvd_pkg::req_type smp;
      if (calm) begin
         // near-still device: gravity mostly on z, small noise
         smp.accel_x = gzvd_pkg::SAMPLE_W'($urandom_range(0, 4000)) - 24'sd2000;
         smp.accel_y = gzvd_pkg::SAMPLE_W'($urandom_range(0, 4000)) - 24'sd2000;
         smp.accel_z = 24'sd643430 + gzvd_pkg::SAMPLE_W'($urandom_range(0, 4000)) - 24'sd2000;
         smp.rate_x = gzvd_pkg::SAMPLE_W'($urandom_range(0, 2000)) - 24'sd1000;
         smp.rate_y = gzvd_pkg::SAMPLE_W'($urandom_range(0, 2000)) - 24'sd1000;
         smp.rate_z = gzvd_pkg::SAMPLE_W'($urandom_range(0, 2000)) - 24'sd1000;
      end else begin
         smp = REQ_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
      end
      return smp;
   endfunction

   function automatic gzvd_pkg::req_type uniform_sample(
         input logic signed [gzvd_pkg::SAMPLE_W-1:0] a,
         input logic signed [gzvd_pkg::SAMPLE_W-1:0] r);
      return '{a, a, a, r, r, r};
   endfunction

   // full-scale extremes, the first of which fill the window silently, then calm samples
   task automatic test_fill_and_extremes();
      send_sample(uniform_sample(S_MAX, S_MAX));
      send_sample(uniform_sample(S_MIN, S_MIN));
      send_sample(uniform_sample(S_MAX, S_MIN));
      send_sample(uniform_sample(S_MIN, S_MAX));
      send_sample('{S_MIN, S_MAX, S_MIN, 24'sd0, 24'sd1, -24'sd1});
      send_sample('{S_MAX, S_MIN, S_MAX, 24'sd0, 24'sd0, 24'sd0});
      send_sample(make_sample(1'b1));
      send_sample(make_sample(1'b1));
      send_sample(make_sample(1'b1));
   endtask

   // all-zero force makes the norm zero and drops the gravity term
   task automatic test_zero_force();
      repeat (3) send_sample(uniform_sample(24'sd0, 24'sd0));
      send_sample(uniform_sample(24'sd0, S_MIN));
      // balanced signs that cancel per axis
      send_sample(uniform_sample(24'sd5, 24'sd0));
      send_sample(uniform_sample(-24'sd5, 24'sd0));
      send_sample(uniform_sample(24'sd0, 24'sd0));
   endtask

   // largest registers with extreme samples, then the smallest with random samples
   task automatic test_config_extremes();
      write_all({gzvd_pkg::GRAV_W{1'b1}}, {gzvd_pkg::WEIGHT_W{1'b1}},
                {gzvd_pkg::WEIGHT_W{1'b1}}, STAT_MAX);
      write_reg(CSR_UNMAPPED, {gzvd_pkg::CSR_DATA_W{1'b1}});
      send_sample(uniform_sample(S_MIN, S_MIN));
      send_sample(uniform_sample(S_MAX, S_MAX));
      send_sample(uniform_sample(S_MAX, S_MIN));
      send_sample(make_sample(1'b1));
      drain();
      write_all('0, '0, '0, '0);
      repeat (3) send_sample(make_sample(1'b0));
      drain();
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) send_sample(make_sample($urandom_range(99) < 60));
   endtask

   // response side: random stall, checked on the falling clock edge before the accepting edge
   always @(posedge clock) begin
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 8);
   end

   always @(negedge clock) begin
      gzvd_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stat_queue.size() == 0) begin
            $error("unexpected result transaction: statistic %0h", rsp_data.test_statistic);
            fail_count++;
         end else begin
            exp_rsp = stat_queue.pop_front();
            if (rsp_data.test_statistic !== exp_rsp.test_statistic) begin
               $error("test_statistic: expected %0h, actual %0h",
                      exp_rsp.test_statistic, rsp_data.test_statistic);
               fail_count++;
            end
            if (rsp_data.stationary !== exp_rsp.stationary) begin
               $error("stationary: expected %0b, actual %0b",
                      exp_rsp.stationary, rsp_data.stationary);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** glrt_zero_velocity_detector_core: FAILED **");
         $finish;
      end
   end

   initial begin
      mdl_gravity = gzvd_pkg::GRAVITY_RESET;
      mdl_accel_w = gzvd_pkg::ACCEL_W_RESET;
      mdl_gyro_w = gzvd_pkg::GYRO_W_RESET;
      mdl_threshold = gzvd_pkg::THRESHOLD_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_and_extremes();
      test_zero_force();
      drain();
      test_config_extremes();

      // reset-like settings with random threshold, long stretch without idling
      write_all(gzvd_pkg::GRAVITY_RESET, gzvd_pkg::ACCEL_W_RESET, gzvd_pkg::GYRO_W_RESET,
                gzvd_pkg::STAT_W'({$urandom(), $urandom()}));
      quiet = 1'b1;
      test_random(250);
      quiet = 1'b0;
      drain();

      // fully random settings
      write_all(gzvd_pkg::GRAV_W'($urandom()), gzvd_pkg::WEIGHT_W'($urandom()),
                gzvd_pkg::WEIGHT_W'($urandom()), gzvd_pkg::STAT_W'({$urandom(), $urandom()}));
      test_random(300);
      drain();

      // back to reset values
      write_all(gzvd_pkg::GRAVITY_RESET, gzvd_pkg::ACCEL_W_RESET, gzvd_pkg::GYRO_W_RESET,
                gzvd_pkg::THRESHOLD_RESET);
      test_random(280);
      drain();

      if (fail_count == 0)
         $display("** glrt_zero_velocity_detector_core: PASSED **");
      else
         $display("** glrt_zero_velocity_detector_core: FAILED **");
      $finish;
   end

endmodule
